FILE: sv/kpc_pkg.sv
// Shared types and constants of the key press classifier.
package kpc_pkg;

  localparam int KEY_W   = 4;
  localparam int COUNT_W = 10;
  localparam int KIND_W  = 3;
  localparam int ADDR_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [COUNT_W-1:0] SHORT_RST  = 10'd3;
  localparam logic [COUNT_W-1:0] LONG_RST   = 10'd100;
  localparam logic [COUNT_W-1:0] REPEAT_RST = 10'd110;

  localparam logic [ADDR_W-1:0] CFG_SHORT  = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_LONG   = 2'd1;
  localparam logic [ADDR_W-1:0] CFG_REPEAT = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    EV_SHORT_START   = 3'd0,
    EV_LONG_START    = 3'd1,
    EV_LONG_REPEAT   = 3'd2,
    EV_SHORT_RELEASE = 3'd3,
    EV_LONG_RELEASE  = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0] short_thr;
    logic [COUNT_W-1:0] long_thr;
    logic [COUNT_W-1:0] repeat_thr;
  } thr_t;

  typedef struct packed {
    logic             valid;
    ev_kind_t         kind;
    logic [KEY_W-1:0] keys;
  } evt_t;

endpackage

FILE: sv/kpc_in_if.sv
// Input channel carrying one sampled key mask per beat.
interface kpc_in_if;
  logic                       valid;
  logic                       ready;
  logic [kpc_pkg::KEY_W-1:0]  pressed_mask;
  modport source (output valid, output pressed_mask, input ready);
  modport sink   (input valid, input pressed_mask, output ready);
endinterface

FILE: sv/kpc_out_if.sv
// Result channel carrying one classified key event per beat.
interface kpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [kpc_pkg::KIND_W-1:0] event_kind;
  logic [kpc_pkg::KEY_W-1:0]  event_keys;
  modport source (output valid, output event_kind, output event_keys, input ready);
  modport sink   (input valid, input event_kind, input event_keys, output ready);
endinterface

FILE: sv/kpc_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface kpc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kpc_pkg::ADDR_W-1:0]  addr;
  logic [kpc_pkg::COUNT_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: sv/kpc_cfg_regs.sv
// Threshold registers written through the configuration channel.
module kpc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  kpc_cfg_if.sink       cfg_ch,
  output kpc_pkg::thr_t thr
);
  import kpc_pkg::*;

  thr_t thr_r;
  thr_t thr_nxt;

  assign cfg_ch.ready = 1'b1;
  assign thr          = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_SHORT:  thr_nxt.short_thr  = cfg_ch.data;
        CFG_LONG:   thr_nxt.long_thr   = cfg_ch.data;
        CFG_REPEAT: thr_nxt.repeat_thr = cfg_ch.data;
        default:    thr_nxt = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.short_thr  <= SHORT_RST;
      thr_r.long_thr   <= LONG_RST;
      thr_r.repeat_thr <= REPEAT_RST;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule

FILE: sv/kpc_classify.sv
// Hold counter, previous mask and event decision for one sample per cycle.
module kpc_classify (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic [kpc_pkg::KEY_W-1:0] mask,
  input  kpc_pkg::thr_t             thr,
  output kpc_pkg::evt_t             evt
);
  import kpc_pkg::*;

  logic [KEY_W-1:0]   prev_mask_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    count_inc = (count_r < COUNT_MAX) ? count_r + 1'b1 : count_r;
    count_nxt = count_r;
    evt.valid = 1'b0;
    evt.kind  = EV_SHORT_START;
    evt.keys  = mask;
    if (mask == prev_mask_r) begin
      if (mask != '0) begin
        count_nxt = count_inc;
        if (count_inc >= thr.repeat_thr) begin
          count_nxt = thr.long_thr;
          evt.valid = 1'b1;
          evt.kind  = EV_LONG_REPEAT;
        end else if (count_inc == thr.long_thr) begin
          evt.valid = 1'b1;
          evt.kind  = EV_LONG_START;
        end else if (count_inc == thr.short_thr) begin
          evt.valid = 1'b1;
          evt.kind  = EV_SHORT_START;
        end
      end
    end else begin
      count_nxt = '0;
      if (mask == '0) begin
        evt.keys = prev_mask_r;
        if (count_r >= thr.long_thr) begin
          evt.valid = 1'b1;
          evt.kind  = EV_LONG_RELEASE;
        end else if (count_r >= thr.short_thr) begin
          evt.valid = 1'b1;
          evt.kind  = EV_SHORT_RELEASE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mask_r <= '0;
      count_r     <= '0;
    end else if (advance) begin
      prev_mask_r <= mask;
      count_r     <= count_nxt;
    end
  end

endmodule

FILE: sv/key_press_classifier.sv
// Key press classifier top level: input register, classifier, result register.
// Path: a sample waits in the input register; its event, if any, goes to the result register.
// Throughput: one sample beat per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset: synchronous, active low; clears both valid flags, the previous mask and the
// hold count, and loads thresholds 3, 100 and 110.
module key_press_classifier #(
  parameter int KEYS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  kpc_in_if.sink    in_ch,
  kpc_out_if.source out_ch,
  kpc_cfg_if.sink   cfg_ch
);
  import kpc_pkg::*;

  localparam int KEY_BITS = (KEYS < KEY_W) ? KEYS : KEY_W;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((1 << KEY_BITS) - 1);

  thr_t thr;
  evt_t evt;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [KEY_W-1:0] s1_mask_r;
  logic             s1_fire;
  logic             in_fire;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [KEY_W-1:0]  out_keys_r;

  kpc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .thr    (thr)
  );

  kpc_classify u_cls (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_fire),
    .mask    (s1_mask_r),
    .thr     (thr),
    .evt     (evt)
  );

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = evt.valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mask_r <= in_ch.pressed_mask & KEY_MASK;
    end
    if (s1_fire) begin
      out_kind_r <= evt.kind;
      out_keys_r <= evt.keys;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.event_keys = out_keys_r;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("result valid after reset");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !(s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("sample accepted over a stalled input register");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.event_kind <= EV_LONG_RELEASE)
    else $error("event kind out of range");

  a_keys_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.event_keys != '0)
    else $error("event without keys");

endmodule
